@@ hdl/wpdi_pkg.sv @@
`timescale 1ns / 1ps
package wpdi_pkg;
  localparam int SampleBits = 16;
  localparam int CordicSteps = 24;
  localparam int PreShift = 46 - SampleBits;
  localparam int CordW = 48;
  localparam int DaccW = 42;
  localparam int WaccW = 26;
  localparam int QW = 44;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegSolX = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSolY = 1'b1;
  localparam logic [WaccW-1:0] WaccMax = {WaccW{1'b1}};
  localparam logic signed [DaccW-1:0] DaccMax = {1'b0, {(DaccW-1){1'b1}}};
  localparam logic signed [DaccW-1:0] DaccMin = {1'b1, {(DaccW-1){1'b0}}};

  typedef struct packed {
    logic signed [15:0] meas_re;
    logic signed [15:0] meas_im;
    logic signed [15:0] pred_re;
    logic signed [15:0] pred_im;
    logic [15:0] weight;
    logic signed [15:0] sol;
  } lane_in_t;

  typedef struct packed {
    logic signed [DaccW-1:0] dacc;
    logic [WaccW-1:0] wacc;
  } lane_out_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;       5'd21: r = 32'd325;
      5'd22: r = 32'd162;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage

@@ hdl/wpdi_lane.sv @@
`timescale 1ns / 1ps
// One polarization: two CORDICs iterated in step, then multiply and accumulate.
module wpdi_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                clear_i,
  input  wpdi_pkg::lane_in_t  in_i,
  output logic                done_o,
  output wpdi_pkg::lane_out_t acc_o
);
  localparam int W = wpdi_pkg::CordW;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIter = 2'd1;
  localparam logic [1:0] StMul = 2'd2;
  localparam logic [1:0] StAcc = 2'd3;

  logic [1:0] st_q, st_d;
  logic [4:0] it_q, it_d;
  logic signed [W-1:0] mx_q, my_q, px_q, py_q, mx_d, my_d, px_d, py_d;
  logic [31:0] mz_q, pz_q, mz_d, pz_d;
  logic mzero_q, pzero_q, mzero_d, pzero_d;
  logic [15:0] w_q, w_d, sol_q, sol_d;
  logic signed [31:0] prod_q, prod_d;
  logic signed [wpdi_pkg::DaccW-1:0] dacc_q, dacc_d;
  logic [wpdi_pkg::WaccW-1:0] wacc_q, wacc_d;
  logic [15:0] am, ap, diff;
  logic signed [wpdi_pkg::DaccW:0] dsum;
  logic [wpdi_pkg::WaccW:0] wsum;
  logic [31:0] mzr, pzr;

  function automatic logic [W+W+32:0] prerot(input logic signed [15:0] re,
                                             input logic signed [15:0] im);
    logic signed [W-1:0] x, y;
    logic [31:0] z;
    x = W'(re);
    y = W'(im);
    z = 32'd0;
    if (re < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    x = x <<< wpdi_pkg::PreShift;
    y = y <<< wpdi_pkg::PreShift;
    return {x, y, z, (re == 16'sd0) && (im == 16'sd0)};
  endfunction

  always_comb begin
    mx_d = mx_q; my_d = my_q; mz_d = mz_q; mzero_d = mzero_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q; pzero_d = pzero_q;
    w_d = w_q; sol_d = sol_q; st_d = st_q; it_d = it_q;
    prod_d = prod_q; dacc_d = dacc_q; wacc_d = wacc_q;
    mzr = mz_q + 32'h8000;
    pzr = pz_q + 32'h8000;
    am = mzero_q ? 16'd0 : mzr[31:16];
    ap = pzero_q ? 16'd0 : pzr[31:16];
    diff = ap - (am - sol_q);
    dsum = (wpdi_pkg::DaccW+1)'(dacc_q) + (wpdi_pkg::DaccW+1)'(prod_q);
    wsum = (wpdi_pkg::WaccW+1)'(wacc_q) + (wpdi_pkg::WaccW+1)'(w_q);
    done_o = 1'b0;
    if (clear_i) begin
      dacc_d = '0;
      wacc_d = '0;
    end
    case (st_q)
      StIdle: if (start_i) begin
        {mx_d, my_d, mz_d, mzero_d} = prerot(in_i.meas_re, in_i.meas_im);
        {px_d, py_d, pz_d, pzero_d} = prerot(in_i.pred_re, in_i.pred_im);
        w_d = in_i.weight;
        sol_d = in_i.sol;
        it_d = '0;
        st_d = StIter;
      end
      StIter: begin
        if (my_q > 0) begin
          mx_d = mx_q + (my_q >>> it_q); my_d = my_q - (mx_q >>> it_q);
          mz_d = mz_q + wpdi_pkg::atan_lut(it_q);
        end else begin
          mx_d = mx_q - (my_q >>> it_q); my_d = my_q + (mx_q >>> it_q);
          mz_d = mz_q - wpdi_pkg::atan_lut(it_q);
        end
        if (py_q > 0) begin
          px_d = px_q + (py_q >>> it_q); py_d = py_q - (px_q >>> it_q);
          pz_d = pz_q + wpdi_pkg::atan_lut(it_q);
        end else begin
          px_d = px_q - (py_q >>> it_q); py_d = py_q + (px_q >>> it_q);
          pz_d = pz_q - wpdi_pkg::atan_lut(it_q);
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(wpdi_pkg::CordicSteps - 1)) st_d = StMul;
      end
      StMul: begin
        prod_d = 32'($signed(diff) * $signed({1'b0, w_q}));
        st_d = StAcc;
      end
      StAcc: begin
        if (dsum > (wpdi_pkg::DaccW+1)'(wpdi_pkg::DaccMax)) dacc_d = wpdi_pkg::DaccMax;
        else if (dsum < (wpdi_pkg::DaccW+1)'(wpdi_pkg::DaccMin)) dacc_d = wpdi_pkg::DaccMin;
        else dacc_d = dsum[wpdi_pkg::DaccW-1:0];
        wacc_d = wsum[wpdi_pkg::WaccW] ? wpdi_pkg::WaccMax : wsum[wpdi_pkg::WaccW-1:0];
        done_o = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      it_q <= '0;
      dacc_q <= '0;
      wacc_q <= '0;
    end else begin
      st_q <= st_d;
      it_q <= it_d;
      dacc_q <= dacc_d;
      wacc_q <= wacc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d; my_q <= my_d; mz_q <= mz_d; mzero_q <= mzero_d;
    px_q <= px_d; py_q <= py_d; pz_q <= pz_d; pzero_q <= pzero_d;
    w_q <= w_d; sol_q <= sol_d; prod_q <= prod_d;
  end

  assign acc_o = '{dacc: dacc_q, wacc: wacc_q};

  ap_it_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIter |-> it_q < 5'(wpdi_pkg::CordicSteps)) else $error("iteration overrun");
  ap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> st_q == StIdle) else $error("done not idle");
  ap_wsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_q) == StAcc && !$past(clear_i) |-> wacc_q >= $past(wacc_q))
    else $error("weight sum fell");
endmodule

@@ hdl/wpdi_merge.sv @@
`timescale 1ns / 1ps
// Rounded mean by restoring division, one quotient bit a cycle, both lanes together.
module wpdi_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  wpdi_pkg::lane_out_t x_i,
  input  wpdi_pkg::lane_out_t y_i,
  output logic                done_o,
  output logic [15:0]         mx_o,
  output logic [15:0]         my_o
);
  localparam int QW = wpdi_pkg::QW;
  localparam int DW = wpdi_pkg::WaccW + 1;
  logic busy_q, busy_d;
  logic [5:0] cnt_q, cnt_d;
  logic [QW-1:0] nx_q, ny_q, nx_d, ny_d;
  logic [DW:0] rx_q, ry_q, rx_d, ry_d;
  logic [DW-1:0] dx_q, dy_q, dx_d, dy_d;
  logic sx_q, sy_q, sx_d, sy_d;
  logic [DW:0] tx, ty;

  function automatic logic [QW-1:0] numer(input wpdi_pkg::lane_out_t a);
    logic [wpdi_pkg::DaccW-1:0] m;
    m = a.dacc[wpdi_pkg::DaccW-1] ? -a.dacc : a.dacc;
    return {m, 1'b0} + QW'(a.wacc);
  endfunction

  function automatic logic [15:0] fin(input logic [QW-1:0] q, input logic s,
                                      input logic [DW-1:0] d);
    logic [15:0] r;
    if (d == '0) r = 16'd0;
    else if (s) r = (q > QW'(32768)) ? 16'h8000 : 16'(-q);
    else r = (q > QW'(32767)) ? 16'h7fff : q[15:0];
    return r;
  endfunction

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; nx_d = nx_q; ny_d = ny_q;
    rx_d = rx_q; ry_d = ry_q; dx_d = dx_q; dy_d = dy_q; sx_d = sx_q; sy_d = sy_q;
    done_o = 1'b0;
    tx = {rx_q[DW-1:0], nx_q[QW-1]};
    ty = {ry_q[DW-1:0], ny_q[QW-1]};
    if (!busy_q) begin
      if (start_i) begin
        nx_d = numer(x_i); ny_d = numer(y_i);
        dx_d = {x_i.wacc, 1'b0}; dy_d = {y_i.wacc, 1'b0};
        sx_d = x_i.dacc[wpdi_pkg::DaccW-1]; sy_d = y_i.dacc[wpdi_pkg::DaccW-1];
        rx_d = '0; ry_d = '0; cnt_d = '0; busy_d = 1'b1;
      end
    end else begin
      nx_d = {nx_q[QW-2:0], tx >= {1'b0, dx_q}};
      ny_d = {ny_q[QW-2:0], ty >= {1'b0, dy_q}};
      rx_d = (tx >= {1'b0, dx_q}) ? tx - {1'b0, dx_q} : tx;
      ry_d = (ty >= {1'b0, dy_q}) ? ty - {1'b0, dy_q} : ty;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(QW - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign mx_o = fin(nx_d, sx_q, dx_q);
  assign my_o = fin(ny_d, sy_q, dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d; ny_q <= ny_d; rx_q <= rx_d; ry_q <= ry_d;
    dx_q <= dx_d; dy_q <= dy_d; sx_q <= sx_d; sy_q <= sy_d;
  end

  ap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < 6'(QW)) else $error("divider overrun");
  ap_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("start while dividing");
  ap_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != 6'd0 |-> rx_q < {1'b0, dx_q} || dx_q == '0)
    else $error("remainder too big");
endmodule

@@ hdl/weighted_phase_difference_integrator.sv @@
`timescale 1ns / 1ps
// Weighted phase difference integrator, X and Y lanes side by side.
// Input stream s_axis: one item per timestep, tlast closes a run.
// Output stream m_axis: one result item per run, sent after the last item.
// Configuration: cfg_we_i writes solution phase X (index 0) or Y (index 1);
// the user is to write them only while idle; the block itself does not enforce it.
// Each item goes through load, 24 CORDIC iterations run in step for the
// measured and predicted vectors of a lane, one multiply, one accumulate.
// tready is high only while the lanes are idle and no divide is pending,
// so a new item is not taken before the last one is through. A last item
// then hands the sums to the divider for the bit-serial rounded divide;
// the result sits in the output register until taken. The next run's items
// are accepted meanwhile, but its divide does not start, and its last item
// holds tready low, until the register is empty.
// Reset clears accumulators, the solution phases and all handshake state.
// A stalled receiver holds m_axis_tdata stable.
module weighted_phase_difference_integrator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // meas_x_re, meas_x_im, meas_y_re, meas_y_im, pred_x_re, pred_x_im,
  // pred_y_re, pred_y_im, weight_x, weight_y
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mean_phase_x, mean_phase_y, weight_sum_x, weight_sum_y, zero pad
  output logic [87:0]  m_axis_tdata
);
  logic [15:0] solx_q, soly_q;
  logic busy_q, last_q, divp_q, pend_q, ovalid_q;
  logic [83:0] res_q;
  wpdi_pkg::lane_in_t lx, ly;
  wpdi_pkg::lane_out_t ox, oy;
  logic dx, dy, ddone;
  logic [15:0] mx, my;
  logic accept, fin, mstart;

  assign s_axis_tready = !busy_q && !(divp_q);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign fin = dx && last_q;
  assign mstart = pend_q && !ovalid_q;

  assign lx = '{meas_re: s_axis_tdata[15:0], meas_im: s_axis_tdata[31:16],
               pred_re: s_axis_tdata[79:64], pred_im: s_axis_tdata[95:80],
               weight: s_axis_tdata[143:128], sol: solx_q};
  assign ly = '{meas_re: s_axis_tdata[47:32], meas_im: s_axis_tdata[63:48],
               pred_re: s_axis_tdata[111:96], pred_im: s_axis_tdata[127:112],
               weight: s_axis_tdata[159:144], sol: soly_q};

  wpdi_lane u_lane_x (.clk_i, .rst_ni, .start_i(accept), .clear_i(ddone),
    .in_i(lx), .done_o(dx), .acc_o(ox));
  wpdi_lane u_lane_y (.clk_i, .rst_ni, .start_i(accept), .clear_i(ddone),
    .in_i(ly), .done_o(dy), .acc_o(oy));
  wpdi_merge u_merge (.clk_i, .rst_ni, .start_i(mstart), .x_i(ox), .y_i(oy),
    .done_o(ddone), .mx_o(mx), .my_o(my));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solx_q <= '0; soly_q <= '0; busy_q <= 1'b0; last_q <= 1'b0;
      divp_q <= 1'b0; pend_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == wpdi_pkg::RegSolX) solx_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == wpdi_pkg::RegSolY) soly_q <= cfg_data_i;
      if (accept) begin
        busy_q <= 1'b1;
        last_q <= s_axis_tlast;
      end else if (dx) begin
        busy_q <= 1'b0;
      end
      if (fin) divp_q <= 1'b1;
      else if (ddone) divp_q <= 1'b0;
      if (fin) pend_q <= 1'b1;
      else if (mstart) pend_q <= 1'b0;
      if (ddone) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ddone) res_q <= {oy.wacc, ox.wacc, my, mx};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'd0, res_q};

  ap_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx == dy) else $error("lanes out of step");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddone |-> !ovalid_q || m_axis_tready) else $error("result overwritten");
  ap_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divp_q |-> !accept) else $error("item during divide");
endmodule
